/* hw/rtl/multi_queue_round_robin_fifo_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-queue round-robin FIFO
// Concurrent checks on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_ROUND_ROBIN_FIFO_DEFINES_SVH
`define MULTI_QUEUE_ROUND_ROBIN_FIFO_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication
`define MQRR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mqrr assertion failed");
// Next-cycle implication
`define MQRR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mqrr assertion failed");
`else
`define MQRR_ASSERT_NOW(lbl, ante, cons)
`define MQRR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/mqrr_pkg.sv */
// ----------------------------------------------------------------------------
// mqrr_pkg
// Types, codes and widths shared by the multi-queue round-robin FIFO.
// ----------------------------------------------------------------------------
package mqrr_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int NUM_QUEUES_DEF  = 8;

	localparam int MODE_W     = 3;
	localparam int QSEL_W     = 3;
	localparam int DATA_W     = 32;
	localparam int KIND_W     = 8;
	localparam int CNT_W      = 6;
	localparam int STATUS_W   = 2;
	localparam int LEVEL_W    = 6;
	localparam int SERVED_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 48;
	localparam int TUSER_W     = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_TAIL  = 3'd0,
		MODE_PUSH_HEAD  = 3'd1,
		MODE_POP        = 3'd2,
		MODE_DISCARD    = 3'd3,
		MODE_PEEK_FIRST = 3'd4,
		MODE_PEEK_LAST  = 3'd5,
		MODE_PEEK_NTH   = 3'd6,
		MODE_CLEAR      = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SERVED  = 2'd0,
		CFG_BREADTH = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] data;
	} item_t;

	typedef struct packed {
		mode_t             mode;
		logic [QSEL_W-1:0] queue_sel;
		logic [DATA_W-1:0] payload;
		logic [KIND_W-1:0] item_kind;
		logic [CNT_W-1:0]  keep_count;
		logic [CNT_W-1:0]  position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [QSEL_W-1:0]  from_queue;
		logic [LEVEL_W-1:0] level;
		logic               use_data;
	} res_t;

endpackage

/* hw/rtl/mqrr_store.sv */
// ----------------------------------------------------------------------------
// mqrr_store
// Item memory for all queues: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mqrr_store import mqrr_pkg::*; #(
	parameter int ENTRIES = QUEUE_DEPTH_DEF * NUM_QUEUES_DEF,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  item_t         wr_item,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output item_t         rd_item
);

	item_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_item;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_item <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/mqrr_scan.sv */
// ----------------------------------------------------------------------------
// mqrr_scan
// Rotating find-first over the served queues; next scan start.
// ----------------------------------------------------------------------------
module mqrr_scan import mqrr_pkg::*; #(
	parameter int NUM_QUEUES = NUM_QUEUES_DEF,
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
	localparam int NW = $clog2(NUM_QUEUES + 1)
) (
	input  logic [NUM_QUEUES-1:0] nonempty,
	input  logic [SERVED_W-1:0]   served,
	input  logic [QW-1:0]         offset,
	output logic                  found,
	output logic [QW-1:0]         pick,
	output logic [QW-1:0]         next_offset
);

	localparam int RW = QW + NW;
	localparam int CW = SERVED_W + 1;

	logic [NW-1:0]         n;
	logic [RW-1:0]         rem;
	logic [RW-1:0]         rem_inc;
	logic [QW-1:0]         start;
	logic [NUM_QUEUES-1:0] cand;
	logic [NUM_QUEUES-1:0] hi;
	logic [NUM_QUEUES-1:0] vec;

	// clamp the served count to 1..NUM_QUEUES
	always_comb begin
		if (served == '0) begin
			n = NW'(1);
		end else if (CW'(served) > CW'(NUM_QUEUES)) begin
			n = NW'(NUM_QUEUES);
		end else begin
			n = NW'(served);
		end
	end

	// offset mod n by restoring steps; offset stays below 2**QW
	always_comb begin
		rem = RW'(offset);
		for (int j = QW - 1; j >= 0; j--) begin
			if (rem >= (RW'(n) << j)) begin
				rem = rem - (RW'(n) << j);
			end
		end
	end

	assign start       = QW'(rem);
	assign rem_inc     = rem + RW'(1);
	assign next_offset = (rem_inc == RW'(n)) ? '0 : QW'(rem_inc);

	always_comb begin
		for (int k = 0; k < NUM_QUEUES; k++) begin
			cand[k] = nonempty[k] && (NW'(k) < n);
			hi[k]   = cand[k] && (QW'(k) >= start);
		end
	end

	assign found = |cand;
	assign vec   = (|hi) ? hi : cand;

	// lowest set bit wins
	always_comb begin
		pick = '0;
		for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
			if (vec[k]) begin
				pick = QW'(k);
			end
		end
	end

endmodule

/* hw/rtl/multi_queue_round_robin_fifo.sv */
// ----------------------------------------------------------------------------
// multi_queue_round_robin_fifo
// Up to eight ring-buffer queues of typed items with a round-robin pop.
// ----------------------------------------------------------------------------
// Usage: each request on the s_t* stream carries a mode, a queue number, an
// item word and kind, a keep count and a peek position; every request
// returns exactly one result on the m_t* stream (status, item, source queue
// and level). Modes: push tail, push head, pop, discard, peek first, peek
// last, peek nth, clear. Pop scans the served queues from a rotating start.
// The user writes served_queues and breadth_first on the cfg_* channel only
// while no request is in flight; the block does not enforce it. cfg_ready is
// always high. Throughput: one request per cycle while m_tready stays high.
// A request waits in the input register, where the pointer pair, the
// find-first and the item memory port are worked in a single pass; its
// result then moves into the output register, which drives m_tvalid.
// Reset: all queues empty, scan start 0, served_queues 1, breadth_first 0.
// There is no clearing pass; item memory is unknown until pushed, and no
// request ever returns an entry that was not pushed.
// Stall: while m_tready is low the result holds, one more request may wait
// in the input register, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "multi_queue_round_robin_fifo_defines.svh"

module multi_queue_round_robin_fifo import mqrr_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// mode[2:0], queue_sel[5:3], payload[37:6], keep_count[43:38],
	// position[49:44], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// item_kind[7:0]
	input  logic [TUSER_W-1:0]     s_tuser,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status[1:0], data_out[33:2], from_queue[36:34], level[42:37],
	// zero fill above
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// kind_out[7:0]
	output logic [TUSER_W-1:0]     m_tuser,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int PW      = $clog2(QUEUE_DEPTH);
	localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SW      = ((PW > CNT_W) ? PW : CNT_W) + 1;
	localparam int OUT_PAD = OUT_TDATA_W - (STATUS_W + DATA_W + QSEL_W + LEVEL_W);

	// wrap-around step of a slot pointer
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + PW'(1));
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(QUEUE_DEPTH - 1) : PW'(p - PW'(1));
	endfunction

	// configuration registers
	logic [SERVED_W-1:0] served_q;
	logic                breadth_q;

	// queue state
	logic [PW-1:0] head_q [NUM_QUEUES];
	logic [PW-1:0] tail_q [NUM_QUEUES];
	logic [QW-1:0] scan_off_q;
	logic [PW-1:0] lvl [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] nonempty;

	// pipeline
	logic  valid_s1;
	req_t  req_s1;
	logic  valid_s2;
	res_t  res_s2;
	logic  adv;
	logic  take_s1;

	// scan results
	logic          scan_found;
	logic [QW-1:0] scan_pick;
	logic [QW-1:0] scan_next;

	// single-pass request logic
	logic          q_ok;
	logic [QW-1:0] a_idx;
	logic [PW-1:0] ha;
	logic [PW-1:0] ta;
	logic [PW-1:0] sz;
	logic [SW-1:0] nth_sum;
	logic [SW-1:0] keep_ext;
	logic [SW-1:0] disc_head;
	logic          upd_head;
	logic          upd_tail;
	logic          upd_off;
	logic [PW-1:0] new_head;
	logic [PW-1:0] new_tail;
	logic [PW-1:0] new_lvl;
	logic [PW-1:0] slot;
	logic          wr_req;
	res_t          res_d;
	logic [AW-1:0] mem_addr;
	item_t         rd_item;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q  <= SERVED_W'(1);
			breadth_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SERVED:  served_q  <= cfg_data;
				CFG_BREADTH: breadth_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------- flow control
	// the output register frees when the consumer takes the result; the input
	// register frees when its request moves into the output register
	assign adv      = !valid_s2 || m_tready;
	assign take_s1  = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// unpack the request on transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.mode       <= mode_t'(s_tdata[2:0]);
			req_s1.queue_sel  <= s_tdata[5:3];
			req_s1.payload    <= s_tdata[37:6];
			req_s1.keep_count <= s_tdata[43:38];
			req_s1.position   <= s_tdata[49:44];
			req_s1.item_kind  <= s_tuser;
		end
	end

	// --------------------------------------------------------- queue levels
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (tail_q[i] >= head_q[i]) begin
				lvl[i] = PW'(tail_q[i] - head_q[i]);
			end else begin
				lvl[i] = PW'((PW + 1)'(tail_q[i]) + (PW + 1)'(QUEUE_DEPTH)
					- (PW + 1)'(head_q[i]));
			end
			nonempty[i] = (head_q[i] != tail_q[i]);
		end
	end

	mqrr_scan #(
		.NUM_QUEUES (NUM_QUEUES)
	) u_scan (
		.nonempty    (nonempty),
		.served      (served_q),
		.offset      (scan_off_q),
		.found       (scan_found),
		.pick        (scan_pick),
		.next_offset (scan_next)
	);

	// ------------------------------------------------------ request decode
	// one queue is touched per request: the popped one or the addressed one
	assign q_ok  = ((QSEL_W + 2)'(req_s1.queue_sel) < (QSEL_W + 2)'(NUM_QUEUES));
	assign a_idx = (req_s1.mode == MODE_POP) ? scan_pick : QW'(req_s1.queue_sel);
	assign ha    = head_q[a_idx];
	assign ta    = tail_q[a_idx];
	assign sz    = lvl[a_idx];

	// head plus position; below twice the depth whenever it is used
	always_comb begin
		nth_sum = SW'(ha) + SW'(req_s1.position);
		if (nth_sum >= SW'(QUEUE_DEPTH)) begin
			nth_sum = nth_sum - SW'(QUEUE_DEPTH);
		end
	end

	// new head for discard: tail minus keep, keep below the level
	assign keep_ext  = SW'(req_s1.keep_count);
	assign disc_head = (SW'(ta) >= keep_ext) ? (SW'(ta) - keep_ext)
		: (SW'(ta) + SW'(QUEUE_DEPTH) - keep_ext);

	always_comb begin
		res_d.status     = ST_OK;
		res_d.from_queue = req_s1.queue_sel;
		res_d.use_data   = 1'b0;
		new_lvl          = sz;
		upd_head         = 1'b0;
		upd_tail         = 1'b0;
		upd_off          = 1'b0;
		new_head         = ha;
		new_tail         = ta;
		slot             = ha;
		wr_req           = 1'b0;

		if (req_s1.mode == MODE_POP) begin
			upd_off = breadth_q;
			if (scan_found) begin
				res_d.from_queue = QSEL_W'(scan_pick);
				res_d.use_data   = 1'b1;
				upd_head         = 1'b1;
				new_head         = ptr_inc(ha);
				new_lvl          = PW'(sz - PW'(1));
			end else begin
				res_d.status     = ST_EMPTY;
				res_d.from_queue = '0;
				new_lvl          = '0;
			end
		end else if (!q_ok) begin
			res_d.status = ST_EMPTY;
			new_lvl      = '0;
		end else begin
			case (req_s1.mode)
				MODE_PUSH_TAIL: begin
					if (sz == PW'(QUEUE_DEPTH - 1)) begin
						res_d.status = ST_FULL;
					end else begin
						slot     = ta;
						wr_req   = 1'b1;
						upd_tail = 1'b1;
						new_tail = ptr_inc(ta);
						new_lvl  = PW'(sz + PW'(1));
					end
				end
				MODE_PUSH_HEAD: begin
					if (sz == PW'(QUEUE_DEPTH - 1)) begin
						res_d.status = ST_FULL;
					end else begin
						slot     = ptr_dec(ha);
						wr_req   = 1'b1;
						upd_head = 1'b1;
						new_head = ptr_dec(ha);
						new_lvl  = PW'(sz + PW'(1));
					end
				end
				MODE_DISCARD: begin
					// a zero keep count leaves the queue alone
					if (req_s1.keep_count != '0 && SW'(sz) > keep_ext) begin
						upd_head = 1'b1;
						new_head = PW'(disc_head);
						new_lvl  = PW'(req_s1.keep_count);
					end
				end
				MODE_PEEK_FIRST: begin
					if (sz == '0) begin
						res_d.status = ST_EMPTY;
					end else begin
						res_d.use_data = 1'b1;
					end
				end
				MODE_PEEK_LAST: begin
					slot = ptr_dec(ta);
					if (sz == '0) begin
						res_d.status = ST_EMPTY;
					end else begin
						res_d.use_data = 1'b1;
					end
				end
				MODE_PEEK_NTH: begin
					slot = PW'(nth_sum);
					if (SW'(req_s1.position) >= SW'(sz)) begin
						res_d.status = ST_EMPTY;
					end else begin
						res_d.use_data = 1'b1;
					end
				end
				MODE_CLEAR: begin
					upd_head = 1'b1;
					upd_tail = 1'b1;
					new_head = '0;
					new_tail = '0;
					new_lvl  = '0;
				end
				default: ;
			endcase
		end
		res_d.level = LEVEL_W'(new_lvl);
	end

	// --------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			scan_off_q <= '0;
		end else if (take_s1) begin
			if (upd_head) begin
				head_q[a_idx] <= new_head;
			end
			if (upd_tail) begin
				tail_q[a_idx] <= new_tail;
			end
			if (upd_off) begin
				scan_off_q <= scan_next;
			end
		end
	end

	// -------------------------------------------------------- item memory
	// a push lands at the edge that ends its cycle, ahead of the next read
	assign mem_addr = AW'(AW'(a_idx) * AW'(QUEUE_DEPTH)) + AW'(slot);

	mqrr_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (take_s1 && wr_req),
		.wr_addr (mem_addr),
		.wr_item ({req_s1.item_kind, req_s1.payload}),
		.rd_en   (adv),
		.rd_addr (mem_addr),
		.rd_item (rd_item)
	);

	// -------------------------------------------------------- result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {
		OUT_PAD'(0),
		res_s2.level,
		res_s2.from_queue,
		res_s2.use_data ? rd_item.data : DATA_W'(0),
		res_s2.status
	};
	assign m_tuser  = res_s2.use_data ? rd_item.kind : KIND_W'(0);

	// ----------------------------------------------------------- assertions
	// an empty result register never blocks the input side
	`MQRR_ASSERT_NOW(a_ready_when_out_free, !valid_s2, s_tready)
	// a transfer in always fills the input register
	`MQRR_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, valid_s1)
	// a request leaving the input register always shows up as a result
	`MQRR_ASSERT_NEXT(a_s1_moves_to_s2, take_s1, valid_s2)
	// the scan only ever picks a queue that holds items
	`MQRR_ASSERT_NOW(a_pick_not_empty, scan_found, nonempty[scan_pick])

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: multi-queue round-robin FIFO testbench
// Streams push, pop, discard, peek and clear requests into the block with
// random gaps and back-pressure on both sides. Every accepted request runs
// through a local copy of the queues, pointers and scan start. Each result
// on the output stream is compared field by field against the oldest
// expectation. Phases switch the served count and the scan policy while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import mqrr_pkg::*;

	localparam int QD           = QUEUE_DEPTH_DEF;
	localparam int QC           = NUM_QUEUES_DEF;
	localparam int STALL_LIMIT  = 3000;  // cycles without any transfer
	localparam int DRAIN_GAP    = 8;     // cycles past the last result before a phase change
	localparam int HOLD_AT      = 400;   // result count that triggers the long receiver stall
	localparam int HOLD_LEN     = 200;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		status_t            status;
		logic [DATA_W-1:0]  data;
		logic [KIND_W-1:0]  kind;
		logic [QSEL_W-1:0]  src;
		logic [LEVEL_W-1:0] level;
	} queue_result_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   s_tvalid   = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata    = '0;
	logic [TUSER_W-1:0]     s_tuser    = '0;
	logic                   m_tvalid;
	logic                   m_tready   = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0]     m_tuser;
	logic                   cfg_valid  = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index  = CFG_SERVED;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;

	// Local copy of the block state
	logic [KIND_W+DATA_W-1:0] item_mem [QC][QD];
	int                       head_q [QC];
	int                       tail_q [QC];
	int                       scan_start  = 0;
	int                       served_reg  = 1;
	bit                       breadth_reg = 1'b0;

	req_t          request_backlog [$];
	queue_result_t expected_results [$];
	req_t          offered_req;
	int            issued       = 0;
	int            accepted     = 0;
	int            results_seen = 0;
	int            mismatches   = 0;
	int            idle_pct     = 36;
	int            hold_left    = 0;
	int            stall_cycles = 0;

	multi_queue_round_robin_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int fill_level(int q);
		return (tail_q[q] + QD - head_q[q]) % QD;
	endfunction

	// Apply one request to the local queues and return the result it gives.
	// queue_sel is three bits wide and QC is eight, so no selector is out of range.
	function automatic queue_result_t apply_request(req_t r);
		queue_result_t res;
		int            q;
		int            size;
		int            n;
		int            k;
		bit            found;
		res    = '0;
		res.status = ST_OK;
		res.src    = r.queue_sel;
		q      = r.queue_sel;
		if (r.mode == MODE_POP) begin
			n = (served_reg == 0) ? 1 : ((served_reg > QC) ? QC : served_reg);
			found = 1'b0;
			for (int i = 0; i < n && !found; i++) begin
				k = (i + scan_start) % n;
				if (head_q[k] != tail_q[k]) begin
					{res.kind, res.data} = item_mem[k][head_q[k]];
					head_q[k] = (head_q[k] + 1) % QD;
					res.src   = QSEL_W'(k);
					res.level = LEVEL_W'(fill_level(k));
					found     = 1'b1;
				end
			end
			if (!found) begin
				res.status = ST_EMPTY;
				res.src    = '0;
				res.level  = '0;
			end
			// the scan start rotates even when nothing was found
			if (breadth_reg)
				scan_start = (scan_start + 1) % n;
		end else begin
			size = fill_level(q);
			case (r.mode)
				MODE_PUSH_TAIL, MODE_PUSH_HEAD: begin
					if ((tail_q[q] + 1) % QD == head_q[q]) begin
						res.status = ST_FULL;
					end else if (r.mode == MODE_PUSH_TAIL) begin
						item_mem[q][tail_q[q]] = {r.item_kind, r.payload};
						tail_q[q] = (tail_q[q] + 1) % QD;
					end else begin
						head_q[q] = (head_q[q] + QD - 1) % QD;
						item_mem[q][head_q[q]] = {r.item_kind, r.payload};
					end
				end
				MODE_DISCARD: begin
					if (r.keep_count != 0 && size > r.keep_count)
						head_q[q] = (tail_q[q] + QD - r.keep_count) % QD;
				end
				MODE_PEEK_FIRST: begin
					if (size == 0)
						res.status = ST_EMPTY;
					else
						{res.kind, res.data} = item_mem[q][head_q[q]];
				end
				MODE_PEEK_LAST: begin
					if (size == 0)
						res.status = ST_EMPTY;
					else
						{res.kind, res.data} = item_mem[q][(tail_q[q] + QD - 1) % QD];
				end
				MODE_PEEK_NTH: begin
					if (r.position >= size)
						res.status = ST_EMPTY;
					else
						{res.kind, res.data} = item_mem[q][(head_q[q] + r.position) % QD];
				end
				default: begin
					head_q[q] = 0;
					tail_q[q] = 0;
				end
			endcase
			res.level = LEVEL_W'(fill_level(q));
		end
		return res;
	endfunction

	function automatic req_t make_request(mode_t mode, int q, logic [DATA_W-1:0] payload,
		logic [KIND_W-1:0] kind, int keep, int pos);
		req_t r;
		r.mode       = mode;
		r.queue_sel  = QSEL_W'(q);
		r.payload    = payload;
		r.item_kind  = kind;
		r.keep_count = CNT_W'(keep);
		r.position   = CNT_W'(pos);
		return r;
	endfunction

	// Random request; push_pct and pop_pct weight the mix, the rest is spread
	// over discard, the three peeks and a rare clear.
	function automatic req_t random_request(int push_pct, int pop_pct, int qmax);
		req_t r;
		int   pick;
		r.queue_sel  = QSEL_W'($urandom_range(qmax));
		r.payload    = $urandom;
		r.item_kind  = KIND_W'($urandom_range(255));
		// mostly keep a deep tail so queues can still fill up
		r.keep_count = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(63))
			: CNT_W'($urandom_range(63, 40));
		r.position   = $urandom_range(1) ? CNT_W'($urandom_range(63)) : CNT_W'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < push_pct) begin
			r.mode = $urandom_range(1) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL;
		end else if (pick < push_pct + pop_pct) begin
			r.mode = MODE_POP;
		end else begin
			pick = $urandom_range(19);
			if (pick == 0)
				r.mode = MODE_CLEAR;
			else if (pick < 5)
				r.mode = MODE_DISCARD;
			else if (pick < 10)
				r.mode = MODE_PEEK_FIRST;
			else if (pick < 15)
				r.mode = MODE_PEEK_LAST;
			else
				r.mode = MODE_PEEK_NTH;
		end
		return r;
	endfunction

	task automatic queue_request(req_t r);
		request_backlog.push_back(r);
		issued++;
	endtask

	// Write one register and mirror it locally once the transfer happens
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SERVED)
			served_reg = val;
		else
			breadth_reg = val[0];
		cfg_valid <= 1'b0;
	endtask

	// Hold until every queued request is taken and answered, then let the pipe settle
	task automatic wait_drained();
		while (accepted != issued || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Request driver: advance to the next backlog entry once the current one transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_request(offered_req));
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
					offered_req = request_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, offered_req.position, offered_req.keep_count,
						offered_req.payload, offered_req.queue_sel, offered_req.mode};
					s_tuser  <= offered_req.item_kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		queue_result_t got;
		queue_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[1:0]);
				got.data   = m_tdata[33:2];
				got.src    = m_tdata[36:34];
				got.level  = m_tdata[42:37];
				got.kind   = m_tuser;
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d unexpected: st=%0d d=%h k=%h q=%0d lvl=%0d",
							results_seen, got.status, got.data, got.kind, got.src,
							got.level);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.data !== want.data ||
						got.kind !== want.kind || got.src !== want.src ||
						got.level !== want.level) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("result %0d: want st=%0d d=%h k=%h q=%0d lvl=%0d",
								results_seen, want.status, want.data, want.kind,
								want.src, want.level);
							$display("  got st=%0d d=%h k=%h q=%0d lvl=%0d",
								got.status, got.data, got.kind, got.src, got.level);
						end
					end
				end
				// one long stall so the block fills up and drops s_tready
				if (results_seen == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int               served_val;
		logic [3:0]       breadth_val;
		int               push_pct;
		int               pop_pct;
		int               qmax;
		int               n_items;
		int               fill_q;
		for (int q = 0; q < QC; q++) begin
			head_q[q] = 0;
			tail_q[q] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset configuration: pop scans queue 0 only, fixed start
		queue_request(make_request(MODE_POP,        0, 32'h0,         8'h00, 5,  9));  // nothing found
		queue_request(make_request(MODE_PEEK_FIRST, 0, 32'h0,         8'h00, 0,  0));  // empty peek
		queue_request(make_request(MODE_PEEK_LAST,  3, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_PEEK_NTH,   0, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_PUSH_TAIL,  0, 32'h0000_0000, 8'h00, 0,  0));
		queue_request(make_request(MODE_PUSH_TAIL,  0, 32'hFFFF_FFFF, 8'hFF, 63, 63));
		queue_request(make_request(MODE_PUSH_HEAD,  0, 32'hA5A5_5A5A, 8'h3C, 21, 42));
		queue_request(make_request(MODE_PUSH_TAIL,  7, 32'h1234_5678, 8'h81, 0,  0));
		queue_request(make_request(MODE_PUSH_HEAD,  7, 32'h8000_0001, 8'h7E, 0,  0));
		queue_request(make_request(MODE_PEEK_FIRST, 0, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_PEEK_LAST,  0, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_PEEK_NTH,   0, 32'h0,         8'h00, 0,  1));
		queue_request(make_request(MODE_PEEK_NTH,   0, 32'h0,         8'h00, 0,  3));  // at level
		queue_request(make_request(MODE_PEEK_NTH,   0, 32'h0,         8'h00, 0,  63));
		queue_request(make_request(MODE_PEEK_NTH,   7, 32'h0,         8'h00, 0,  1));
		queue_request(make_request(MODE_DISCARD,    0, 32'h0,         8'h00, 0,  0));  // keep zero
		queue_request(make_request(MODE_DISCARD,    0, 32'h0,         8'h00, 63, 0));
		queue_request(make_request(MODE_DISCARD,    0, 32'h0,         8'h00, 1,  0));
		queue_request(make_request(MODE_POP,        0, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_POP,        0, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_CLEAR,      7, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_PEEK_LAST,  7, 32'h0,         8'h00, 0,  0));
		queue_request(make_request(MODE_CLEAR,      5, 32'h0,         8'h00, 0,  0));
		wait_drained();

		// Random phases; served counts include zero and values above the queue count
		for (int p = 0; p < 7; p++) begin
			idle_pct = 36;
			case (p)
				0: begin served_val = 8;  breadth_val = 4'b0001; push_pct = 75; pop_pct = 10;
					qmax = 1; n_items = 110; end
				1: begin served_val = 3;  breadth_val = 4'b1110; push_pct = 30; pop_pct = 50;
					qmax = 7; n_items = 160; idle_pct = 0; end
				2: begin served_val = 0;  breadth_val = 4'b1011; push_pct = 45; pop_pct = 30;
					qmax = 7; n_items = 160; end
				3: begin served_val = 15; breadth_val = 4'b1111; push_pct = 40; pop_pct = 35;
					qmax = 7; n_items = 160; end
				4: begin served_val = 5;  breadth_val = 4'b0000; push_pct = 80; pop_pct = 5;
					qmax = 0; n_items = 160; end
				5: begin served_val = 8;  breadth_val = 4'b0101; push_pct = 45; pop_pct = 35;
					qmax = 7; n_items = 160; end
				default: begin served_val = 1; breadth_val = 4'b0010; push_pct = 40;
					pop_pct = 30; qmax = 7; n_items = 120; end
			endcase
			write_reg(CFG_SERVED, CFG_DATA_W'(served_val));
			write_reg(CFG_BREADTH, breadth_val);
			if (p == 0) begin
				// drive one queue past full so pushes get refused
				fill_q = $urandom_range(QC - 1);
				repeat (QD + 2)
					queue_request(make_request($urandom_range(1) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL,
						fill_q, $urandom, KIND_W'($urandom_range(255)),
						$urandom_range(63), $urandom_range(63)));
			end
			repeat (n_items)
				queue_request(random_request(push_pct, pop_pct, qmax));
			wait_drained();
		end

		if (mismatches == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
